@@ hw/rtl/servo_pwm_generator_macros.svh @@
// assertion macros for the servo pwm generator
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef SERVO_PWM_GENERATOR_MACROS_SVH
`define SERVO_PWM_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define SPG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("spg: assertion failed");

// consequent holds in the same cycle as the antecedent
`define SPG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spg: assertion failed");

// consequent holds in the cycle after the antecedent
`define SPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spg: assertion failed");

`else

`define SPG_ASSERT_ALWAYS(lbl, prop)
`define SPG_ASSERT_IMPL(lbl, ante, cons)
`define SPG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/spg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

  // field widths
  localparam int unsigned RotW   = 16;
  localparam int unsigned PulseW = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RotMagW  = 7;
  localparam int unsigned ProdW    = PulseW + RotMagW;
  localparam int unsigned DivInW   = ProdW + 1;

  // default counter width
  localparam int unsigned CountWidthDef = 16;

  // command codes
  localparam logic CmdTick = 1'b0;
  localparam logic CmdSet  = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPeriod = 4'd0;
  localparam logic [CfgIdxW-1:0] RegMin    = 4'd1;
  localparam logic [CfgIdxW-1:0] RegCenter = 4'd2;
  localparam logic [CfgIdxW-1:0] RegMax    = 4'd3;

  // configuration reset values
  localparam logic [PulseW-1:0] PeriodRst = 16'd20000;
  localparam logic [PulseW-1:0] MinRst    = 16'd1000;
  localparam logic [PulseW-1:0] CenterRst = 16'd1500;
  localparam logic [PulseW-1:0] MaxRst    = 16'd2000;

  // rotation range and rounding bias for ceiling division
  localparam logic signed [RotW-1:0] RotMax = 16'sd100;
  localparam logic signed [RotW-1:0] RotMin = -16'sd100;
  localparam logic [RotMagW-1:0] RotFull = 7'd100;
  localparam logic [DivInW-1:0] CeilBias = 24'd99;

  // divide by 100 as a multiply by ceil(2^30 / 100) and a shift by 30
  localparam int unsigned RecipShift = 30;
  localparam logic [DivInW-1:0] RecipMul = 24'd10737419;
  localparam int unsigned RecipProdW = 2 * DivInW;

  // stage after the input register
  typedef struct packed {
    logic                 cmd;
    logic                 upd;
    logic                 neg_r;
    logic [RotMagW-1:0]   rmag;
  } spg_s1_t;

  // stage after the product
  typedef struct packed {
    logic                 cmd;
    logic                 upd;
    logic                 neg_w;
    logic [ProdW-1:0]     mag;
  } spg_s2_t;

  // stage after the quotient
  typedef struct packed {
    logic                 cmd;
    logic                 upd;
    logic                 neg_w;
    logic [PulseW-1:0]    quo;
  } spg_s3_t;

endpackage

`default_nettype wire

@@ hw/rtl/spg_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface spg_cmd_if;
  import spg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic signed [RotW-1:0] rotation;

  modport source (output valid, output cmd, output rotation, input ready);
  modport sink   (input valid, input cmd, input rotation, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/spg_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface spg_res_if;
  import spg_pkg::*;

  logic              valid;
  logic              ready;
  logic              pwm_out;
  logic [PulseW-1:0] pulse_ticks;

  modport source (output valid, output pwm_out, output pulse_ticks, input ready);
  modport sink   (input valid, input pwm_out, input pulse_ticks, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/spg_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface spg_cfg_if;
  import spg_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/servo_pwm_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Servo PWM generator.
// cmd_chan_i carries items: cmd 0 is one timer tick, cmd 1 sets a rotation
// command (clamped to -100..100, ignored when equal to the previous raw value).
// res_chan_o returns one transaction per item: the output level after the item
// and the compare value pending in the shadow register.
// cfg_chan_i writes period, min, centre and max pulse widths; it is always
// ready and must only be used while no item is in flight.
// An accepted item passes through the input register, the product of width
// difference and rotation, the reciprocal multiply for the divide by 100, then
// the state and result register.
// Throughput is one item per cycle; the four stages each hold one transaction
// and empty stages close up, so items keep entering while a result waits.
// If the receiver stalls, the pipeline fills and cmd_chan_i.ready drops once
// all four stages are occupied.
// Reset clears the counter, compares, level and last command, and loads the
// default configuration (20000 / 1000 / 1500 / 2000 ticks).
`include "servo_pwm_generator_macros.svh"

module servo_pwm_generator #(
  parameter int unsigned CountWidth = spg_pkg::CountWidthDef
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  spg_cmd_if.sink   cmd_chan_i,
  spg_res_if.source res_chan_o,
  spg_cfg_if.sink   cfg_chan_i
);
  import spg_pkg::*;

  localparam int unsigned CmpW = (CountWidth > PulseW) ? CountWidth : PulseW;

  // configuration registers
  logic [PulseW-1:0] period_q, min_q, center_q, max_q;

  // pipeline registers
  logic    v1_q, v2_q, v3_q, ov_q;
  spg_s1_t s1_q, s1_d;
  spg_s2_t s2_q, s2_d;
  spg_s3_t s3_q, s3_d;

  // servo state
  logic [CountWidth-1:0] cnt_q, cnt_d, cnt_inc;
  logic [PulseW-1:0]     act_q, act_d;
  logic [PulseW-1:0]     shadow_q, shadow_d;
  logic [RotW-1:0]       last_q;
  logic                  lvl_q, lvl_d;

  // handshake and stage enables
  logic en1, en2, en3, en4;
  logic in_fire, fire4, tick_fire, set_fire;

  // datapath intermediates
  logic signed [PulseW:0]   diff;
  logic [PulseW-1:0]        dmag;
  logic [DivInW-1:0]        div_in;
  logic [RecipProdW-1:0]    recip_prod;
  logic signed [PulseW+1:0] sum;
  logic [PulseW-1:0]        res_width;

  // configuration write port
  assign cfg_chan_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodRst;
      min_q    <= MinRst;
      center_q <= CenterRst;
      max_q    <= MaxRst;
    end else if (cfg_chan_i.valid) begin
      unique case (cfg_chan_i.index)
        RegPeriod: period_q <= cfg_chan_i.data;
        RegMin:    min_q    <= cfg_chan_i.data;
        RegCenter: center_q <= cfg_chan_i.data;
        RegMax:    max_q    <= cfg_chan_i.data;
        default: ;
      endcase
    end
  end

  // stage enables, a stage loads when empty or when its content moves on
  assign en4 = !ov_q || res_chan_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign cmd_chan_i.ready = en1;
  assign in_fire   = cmd_chan_i.valid && en1;
  assign fire4     = v3_q && en4;
  assign tick_fire = fire4 && (s3_q.cmd == CmdTick);
  assign set_fire  = fire4 && (s3_q.cmd == CmdSet);

  // stage 1: repeat filter and clamp
  always_comb begin
    s1_d.cmd   = cmd_chan_i.cmd;
    s1_d.upd   = (cmd_chan_i.cmd == CmdSet) && (cmd_chan_i.rotation != last_q);
    s1_d.neg_r = cmd_chan_i.rotation[RotW-1];
    if (cmd_chan_i.rotation > RotMax || cmd_chan_i.rotation < RotMin) begin
      s1_d.rmag = RotFull;
    end else if (cmd_chan_i.rotation[RotW-1]) begin
      s1_d.rmag = RotMagW'(-cmd_chan_i.rotation);
    end else begin
      s1_d.rmag = cmd_chan_i.rotation[RotMagW-1:0];
    end
  end

  // stage 2: signed width difference times rotation magnitude
  always_comb begin
    if (s1_q.neg_r) begin
      diff = $signed({1'b0, center_q}) - $signed({1'b0, min_q});
    end else begin
      diff = $signed({1'b0, max_q}) - $signed({1'b0, center_q});
    end
    dmag       = diff[PulseW] ? PulseW'(-diff) : diff[PulseW-1:0];
    s2_d.cmd   = s1_q.cmd;
    s2_d.upd   = s1_q.upd;
    s2_d.neg_w = diff[PulseW] ^ s1_q.neg_r;
    s2_d.mag   = ProdW'(dmag) * ProdW'(s1_q.rmag);
  end

  // stage 3: floor division by 100, biased for a negative numerator
  always_comb begin
    div_in     = DivInW'(s2_q.mag) + (s2_q.neg_w ? CeilBias : '0);
    recip_prod = RecipProdW'(div_in) * RecipProdW'(RecipMul);
    s3_d.cmd   = s2_q.cmd;
    s3_d.upd   = s2_q.upd;
    s3_d.neg_w = s2_q.neg_w;
    s3_d.quo   = recip_prod[RecipShift +: PulseW];
  end

  // final: pulse width around the centre, clamped to the field range
  always_comb begin
    if (s3_q.neg_w) begin
      sum = $signed({2'b00, center_q}) - $signed({2'b00, s3_q.quo});
    end else begin
      sum = $signed({2'b00, center_q}) + $signed({2'b00, s3_q.quo});
    end
    if (sum[PulseW+1]) begin
      res_width = '0;
    end else if (sum[PulseW]) begin
      res_width = '1;
    end else begin
      res_width = sum[PulseW-1:0];
    end
  end

  // final: counter, compare and output level
  always_comb begin
    cnt_d    = cnt_q;
    act_d    = act_q;
    shadow_d = shadow_q;
    lvl_d    = lvl_q;
    cnt_inc  = cnt_q + CountWidth'(1);
    if (set_fire && s3_q.upd) begin
      shadow_d = res_width;
    end
    if (tick_fire) begin
      if (cnt_q == '0) begin
        act_d = shadow_q;
        lvl_d = 1'b1;
      end
      // low wins when the compare matches at count zero
      if (CmpW'(cnt_q) == CmpW'(act_d)) begin
        lvl_d = 1'b0;
      end
      cnt_d = (CmpW'(cnt_inc) >= CmpW'(period_q)) ? '0 : cnt_inc;
    end
  end

  // valid bits and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      ov_q     <= 1'b0;
      last_q   <= '0;
      cnt_q    <= '0;
      act_q    <= '0;
      shadow_q <= '0;
      lvl_q    <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_fire;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        ov_q <= v3_q;
      end
      if (in_fire && s1_d.upd) begin
        last_q <= cmd_chan_i.rotation;
      end
      cnt_q    <= cnt_d;
      act_q    <= act_d;
      shadow_q <= shadow_d;
      lvl_q    <= lvl_d;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
    if (en2) begin
      s2_q <= s2_d;
    end
    if (en3) begin
      s3_q <= s3_d;
    end
  end

  // result channel, the state registers hold the result of the last item
  assign res_chan_o.valid       = ov_q;
  assign res_chan_o.pwm_out     = lvl_q;
  assign res_chan_o.pulse_ticks = shadow_q;

  // checks
  `SPG_ASSERT_IMPL(a_stall_only_when_full, !en1, v1_q && v2_q && v3_q && ov_q)
  `SPG_ASSERT_NEXT(a_cnt_in_frame, tick_fire, (CmpW'(cnt_q) < CmpW'(period_q)) || (cnt_q == '0))
  `SPG_ASSERT_NEXT(a_high_at_zero, tick_fire && (cnt_q == '0) && (shadow_q != '0), lvl_q)
  `SPG_ASSERT_NEXT(a_set_holds_timer, set_fire, $stable(cnt_q) && $stable(lvl_q) && $stable(act_q))

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import spg_pkg::*;

  // run shape
  localparam int PhaseCount  = 7;
  localparam int PhaseItems  = 61;
  localparam int SettleTicks = 8;
  localparam int HoldOffLen  = 60;
  localparam int StallLimit  = 2000;
  localparam int PlanRows    = 28;

  typedef struct packed {
    logic              level;
    logic [PulseW-1:0] pulse;
  } pwm_result_t;

  // one row of the directed sequence: either a register write or an item
  typedef struct packed {
    bit                 reg_write;
    logic               cmd;
    logic [RotW-1:0]    value;
    logic [CfgIdxW-1:0] index;
    bit                 typed;
    logic               level;
    logic [PulseW-1:0]  pulse;
  } plan_row_t;

  typedef struct packed {
    logic [PulseW-1:0] period;
    logic [PulseW-1:0] min_w;
    logic [PulseW-1:0] center_w;
    logic [PulseW-1:0] max_w;
  } servo_cfg_t;

  // directed sequence; the index column is unused on item rows
  localparam plan_row_t Plan [PlanRows] = '{
    // after reset: low wins at count zero with an empty shadow
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b1, 1'b0, 16'd0},
    // zero equals the reset command, so it is dropped
    '{1'b0, CmdSet,  16'd0,      RegPeriod, 1'b1, 1'b0, 16'd0},
    '{1'b0, CmdSet,  16'd100,    RegPeriod, 1'b1, 1'b0, 16'd2000},
    '{1'b0, CmdSet,  -16'sd100,  RegPeriod, 1'b1, 1'b0, 16'd1000},
    // field extremes clamp to full rotation
    '{1'b0, CmdSet,  16'h7fff,   RegPeriod, 1'b1, 1'b0, 16'd2000},
    '{1'b0, CmdSet,  16'h8000,   RegPeriod, 1'b1, 1'b0, 16'd1000},
    // repeated raw command
    '{1'b0, CmdSet,  16'h8000,   RegPeriod, 1'b1, 1'b0, 16'd1000},
    '{1'b0, CmdSet,  16'd1,      RegPeriod, 1'b1, 1'b0, 16'd1505},
    '{1'b0, CmdSet,  -16'sd1,    RegPeriod, 1'b1, 1'b0, 16'd1495},
    '{1'b0, CmdSet,  16'd0,      RegPeriod, 1'b1, 1'b0, 16'd1500},
    // run the count up to five
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    // shorter period than the current count, an odd width span above the centre
    '{1'b1, CmdTick, 16'd4,      RegPeriod, 1'b0, 1'b0, 16'd0},
    '{1'b1, CmdTick, 16'd0,      RegMin,    1'b0, 1'b0, 16'd0},
    '{1'b1, CmdTick, 16'd2,      RegCenter, 1'b0, 1'b0, 16'd0},
    '{1'b1, CmdTick, 16'd23,     RegMax,    1'b0, 1'b0, 16'd0},
    // positive rounding down
    '{1'b0, CmdSet,  16'd33,     RegPeriod, 1'b0, 1'b0, 16'd0},
    // count beyond the period returns to zero
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    // negative rounding away from centre
    '{1'b0, CmdSet,  -16'sd33,   RegPeriod, 1'b0, 1'b0, 16'd0},
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    // with the count wrapped, the shadow loads again at zero, then a repeated command
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    '{1'b0, CmdTick, 16'd0,      RegPeriod, 1'b0, 1'b0, 16'd0},
    '{1'b0, CmdSet,  -16'sd33,   RegPeriod, 1'b0, 1'b0, 16'd0}
  };

  // per-phase settings; the fifth entry is replaced by a random one
  localparam servo_cfg_t PhaseCfg [PhaseCount] = '{
    '{16'd1,     16'd0,     16'd0,     16'd0},
    '{16'd37,    16'd3,     16'd12,    16'd30},
    '{16'd65535, 16'd0,     16'd32768, 16'd65535},
    '{16'd20,    16'd15,    16'd8,     16'd2},
    '{16'd10,    16'd2,     16'd5,     16'd9},
    '{16'd9,     16'd65535, 16'd0,     16'd65535},
    '{16'd12,    16'd65535, 16'd65535, 16'd0}
  };

  logic clk;
  logic rst_n;

  spg_cmd_if cmd_if ();
  spg_res_if res_if ();
  spg_cfg_if cfg_if ();

  servo_pwm_generator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cmd_chan_i (cmd_if),
    .res_chan_o (res_if),
    .cfg_chan_i (cfg_if)
  );

  // predictor copy of the configuration and state
  logic [PulseW-1:0]        period_cfg, min_cfg, center_cfg, max_cfg;
  logic [CountWidthDef-1:0] tick_cnt;
  logic [PulseW-1:0]        active_cmp, shadow_cmp;
  logic [RotW-1:0]          last_rot;
  logic                     level_q;

  pwm_result_t expected_outputs [$];
  pwm_result_t head;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  bit failed;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // clamp and map a raw rotation onto a pulse width
  function automatic logic [PulseW-1:0] pulse_for_rotation(input logic signed [RotW-1:0] raw);
    longint r, span, num, q;
    r = raw;
    if (r > 100) r = 100;
    else if (r < -100) r = -100;
    if (r > 0) span = longint'(max_cfg) - longint'(center_cfg);
    else span = longint'(center_cfg) - longint'(min_cfg);
    // negative side: centre minus ceiling equals centre plus floor of span*r/100
    num = span * r;
    q = num / 100;
    if ((num % 100) != 0 && num < 0) q = q - 1;
    q = longint'(center_cfg) + q;
    if (q < 0) q = 0;
    if (q > 65535) q = 65535;
    return PulseW'(q);
  endfunction

  // advance the predictor by one item and return the output it gives
  function automatic pwm_result_t servo_step(input logic c, input logic [RotW-1:0] rot);
    logic [CountWidthDef-1:0] nxt;
    if (c == CmdSet) begin
      if (rot != last_rot) begin
        last_rot   = rot;
        shadow_cmp = pulse_for_rotation(rot);
      end
    end else begin
      if (tick_cnt == '0) begin
        active_cmp = shadow_cmp;
        level_q    = 1'b1;
      end
      if (tick_cnt == active_cmp) level_q = 1'b0;
      nxt = tick_cnt + 1'b1;
      if (nxt >= period_cfg) nxt = '0;
      tick_cnt = nxt;
    end
    return '{level: level_q, pulse: shadow_cmp};
  endfunction

  // offer one item, wait for its transaction, then log what it should give
  task automatic send_item(input logic c, input logic [RotW-1:0] rot,
                           input bit typed, input pwm_result_t typed_res);
    pwm_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.cmd      <= c;
    cmd_if.rotation <= rot;
    do @(posedge clk); while (!cmd_if.ready);
    predicted = servo_step(c, rot);
    expected_outputs.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // stop offering items and let the pipeline empty
  task automatic wait_until_quiet();
    cmd_if.valid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (SettleTicks) @(negedge clk);
  endtask

  // one register write; valid stays up so writes can follow back to back
  task automatic write_servo_reg(input logic [CfgIdxW-1:0] idx, input logic [PulseW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      RegPeriod: period_cfg = val;
      RegMin:    min_cfg    = val;
      RegCenter: center_cfg = val;
      RegMax:    max_cfg    = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // result receiver: random stalls plus one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HoldOffLen) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_outputs.size() == 0) begin
        $error("result transaction with nothing expected: pwm_out %0d pulse_ticks %0d",
               res_if.pwm_out, res_if.pulse_ticks);
        failed = 1'b1;
      end else begin
        head = expected_outputs.pop_front();
        if (res_if.pwm_out !== head.level) begin
          $error("pwm_out mismatch: expected %0d, actual %0d", head.level, res_if.pwm_out);
          failed = 1'b1;
        end
        if (res_if.pulse_ticks !== head.pulse) begin
          $error("pulse_ticks mismatch: expected %0d, actual %0d",
                 head.pulse, res_if.pulse_ticks);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic            c;
    logic [RotW-1:0] rot;
    bit              prev_reg;
    int              sel;
    servo_cfg_t      setting;

    rst_n           = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.cmd      = CmdTick;
    cmd_if.rotation = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = RegPeriod;
    cfg_if.data     = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    failed          = 1'b0;
    prev_reg        = 1'b0;

    // predictor reset state
    period_cfg = PeriodRst;
    min_cfg    = MinRst;
    center_cfg = CenterRst;
    max_cfg    = MaxRst;
    tick_cnt   = '0;
    active_cmp = '0;
    shadow_cmp = '0;
    last_rot   = '0;
    level_q    = 1'b0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sequence
    foreach (Plan[i]) begin
      if (Plan[i].reg_write) begin
        if (!prev_reg) wait_until_quiet();
        write_servo_reg(Plan[i].index, Plan[i].value);
      end else begin
        if (prev_reg) cfg_if.valid <= 1'b0;
        send_item(Plan[i].cmd, Plan[i].value, Plan[i].typed, {Plan[i].level, Plan[i].pulse});
      end
      prev_reg = Plan[i].reg_write;
    end

    // random phases, each with its settings and one of four idling modes
    for (int ph = 0; ph < PhaseCount; ph++) begin
      setting = PhaseCfg[ph];
      if (ph == 4) begin
        setting.period   = PulseW'($urandom_range(60, 1));
        setting.min_w    = PulseW'($urandom_range(70));
        setting.center_w = PulseW'($urandom_range(70));
        setting.max_w    = PulseW'($urandom_range(70));
      end
      wait_until_quiet();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      write_servo_reg(RegPeriod, setting.period);
      write_servo_reg(RegMin, setting.min_w);
      write_servo_reg(RegCenter, setting.center_w);
      write_servo_reg(RegMax, setting.max_w);
      cfg_if.valid <= 1'b0;

      for (int n = 0; n < PhaseItems; n++) begin
        // long receiver hold-off while items keep coming, fills the pipeline
        if (ph == 0 && n == 20) hold_req = 1'b1;
        sel = $urandom_range(99);
        if (sel < 65) begin
          c   = CmdTick;
          rot = RotW'($urandom);
        end else if (sel < 85) begin
          c   = CmdSet;
          rot = RotW'($urandom_range(240)) - 16'd120;
        end else if (sel < 92) begin
          c   = CmdSet;
          rot = last_rot;
        end else begin
          c   = CmdSet;
          rot = RotW'($urandom);
        end
        send_item(c, rot, 1'b0, '0);
      end
    end

    wait_until_quiet();
    if (failed) begin
      $display("tb: failure");
    end else begin
      $display("tb: success");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/spg_pkg.sv
hw/rtl/spg_cmd_if.sv
hw/rtl/spg_res_if.sv
hw/rtl/spg_cfg_if.sv
hw/rtl/servo_pwm_generator.sv
tb/tb.sv
